[sv/stp_pkg.sv]
package stp_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TID_W = 4;
  localparam int CMP_W = (IDX_W > TID_W) ? IDX_W : TID_W;
  localparam int VAL_W = 32;
  localparam int NID_W = 5;
  localparam int MASK_W = 16;

  typedef enum logic [3:0] {
    OP_CREATE      = 4'd0,
    OP_DESTROY     = 4'd1,
    OP_START       = 4'd2,
    OP_STOP        = 4'd3,
    OP_RELOAD      = 4'd4,
    OP_SET_RELOAD  = 4'd5,
    OP_SET_COUNT   = 4'd6,
    OP_SET_MODE    = 4'd7,
    OP_READ_COUNT  = 4'd8,
    OP_READ_STATUS = 4'd9,
    OP_TICK        = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_IDLE    = 2'd1,
    ST_RUNNING = 2'd2
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [VAL_W-1:0]   reload;
    logic [VAL_W-1:0]   count;
    logic               one_shot;
  } slot_rec_t;

  // per-slot outcome reported by the head unit
  typedef struct packed {
    logic               alloc;
    logic               fire;
    logic               rd_hit;
    logic [VAL_W-1:0]   rdata;
  } slot_res_t;

endpackage

[sv/stp_cell.sv]
module stp_cell
  import stp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      shift,
  input  slot_rec_t d,
  output slot_rec_t q
);

  // hold one slot record; take the neighbour's record on each shift
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '{status: ST_FREE, reload: '0, count: '0, one_shot: 1'b0};
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

[sv/stp_head.sv]
module stp_head
  import stp_pkg::*;
(
  input  op_t              op,
  input  logic             hit,
  input  logic             create_ok,
  input  logic [VAL_W-1:0] value,
  input  logic             one_shot,
  input  slot_rec_t        rec_in,
  output slot_rec_t        rec_out,
  output slot_res_t        res
);

  always_comb begin
    rec_out = rec_in;
    res     = '0;
    case (op)
      OP_CREATE: begin
        if (create_ok && rec_in.status == ST_FREE) begin
          rec_out.one_shot = one_shot;
          rec_out.status   = ST_IDLE;
          rec_out.reload   = value;
          rec_out.count    = value;
          res.alloc        = 1'b1;
        end
      end
      OP_DESTROY: begin
        if (hit) begin
          rec_out.count  = '0;
          rec_out.reload = '0;
          rec_out.status = ST_FREE;
        end
      end
      OP_START: begin
        if (hit) begin
          rec_out.count = rec_in.reload;
          if (rec_in.status != ST_FREE) rec_out.status = ST_RUNNING;
        end
      end
      OP_STOP: begin
        if (hit) begin
          rec_out.count = rec_in.reload;
          if (rec_in.status != ST_FREE) rec_out.status = ST_IDLE;
        end
      end
      OP_RELOAD: begin
        if (hit) rec_out.count = rec_in.reload;
      end
      OP_SET_RELOAD: begin
        if (hit) rec_out.reload = value;
      end
      OP_SET_COUNT: begin
        if (hit) rec_out.count = value;
      end
      OP_SET_MODE: begin
        if (hit) rec_out.one_shot = one_shot;
      end
      OP_READ_COUNT: begin
        res.rd_hit = hit;
        res.rdata  = rec_in.count;
      end
      OP_READ_STATUS: begin
        res.rd_hit = hit;
        res.rdata  = VAL_W'(rec_in.status);
      end
      OP_TICK: begin
        if (rec_in.status == ST_RUNNING) begin
          if (rec_in.count != '0) begin
            rec_out.count = rec_in.count - VAL_W'(1);
          end else begin
            // expire: reload, and drop to idle when single shot
            res.fire      = 1'b1;
            rec_out.count = rec_in.reload;
            if (rec_in.one_shot) rec_out.status = ST_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/software_timer_pool_unit.sv]
// Pool of NUM_TIMERS down-counting timers held in a ring of slot cells.
// Every operation, tick included, is accepted and then walks the ring
// once: each cycle the ring rotates one place, the record at the head
// passes through the single update unit and re-enters at the tail, so
// after a full turn every slot is back in place. Create allocates the
// lowest free slot (new_id is NUM_TIMERS when the pool is full); reads
// return the addressed slot's count or status; a tick reports expired
// timers in fired_mask (timers 0 to 15 only). One result beat per input
// beat; the result is registered and the next operation may be taken
// while it waits, though a walk that ends with the previous result still
// stalled holds until it is taken.
module software_timer_pool_unit
  import stp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          op,
  input  logic [TID_W-1:0]    timer_id,
  input  logic [VAL_W-1:0]    value,
  input  logic                one_shot,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [NID_W-1:0]    new_id,
  output logic [VAL_W-1:0]    read_data,
  output logic [MASK_W-1:0]   fired_mask
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  state_t             state;
  logic [IDX_W-1:0]   idx;
  op_t                op_q;
  logic [TID_W-1:0]   tid_q;
  logic [VAL_W-1:0]   value_q;
  logic               one_shot_q;
  logic               found;
  logic [NID_W-1:0]   nid_acc;
  logic [VAL_W-1:0]   rdata_acc;
  logic [MASK_W-1:0]  fired_acc;

  slot_rec_t          ring [NUM_TIMERS];
  slot_rec_t          ring_d [NUM_TIMERS];
  slot_rec_t          head_out;
  slot_res_t          head_res;
  logic               shift;
  logic               hit;
  logic               in_take;
  logic               out_free;
  logic               publish;
  logic [MASK_W-1:0]  fire_bit;

  assign in_take  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign shift    = (state == S_WALK);
  assign out_free = !out_valid || !out_stall;
  assign publish  = ((state == S_WALK && idx == LAST_IDX) || state == S_HOLD) && out_free;
  assign hit      = (CMP_W'(idx) == CMP_W'(tid_q));
  assign fire_bit = MASK_W'(head_res.fire) << idx;

  // ring: each cell takes its upper neighbour, the tail takes the head's update
  always_comb begin
    for (int k = 0; k < NUM_TIMERS - 1; k++) begin
      ring_d[k] = ring[k + 1];
    end
    ring_d[NUM_TIMERS - 1] = head_out;
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    stp_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (ring_d[g]),
      .q     (ring[g])
    );
  end

  stp_head u_head (
    .op        (op_q),
    .hit       (hit),
    .create_ok (!found),
    .value     (value_q),
    .one_shot  (one_shot_q),
    .rec_in    (ring[0]),
    .rec_out   (head_out),
    .res       (head_res)
  );

  // sequencer: accept, walk the ring once, then publish the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      found <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_WALK;
            idx   <= '0;
            found <= 1'b0;
          end
        end
        S_WALK: begin
          if (head_res.alloc) found <= 1'b1;
          if (idx == LAST_IDX) begin
            state <= out_free ? S_IDLE : S_HOLD;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_HOLD: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // operation latch and result accumulators
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_q       <= op_t'(op);
      tid_q      <= timer_id;
      value_q    <= value;
      one_shot_q <= one_shot;
      nid_acc    <= (op_t'(op) == OP_CREATE) ? NID_W'(NUM_TIMERS) : '0;
      rdata_acc  <= '0;
      fired_acc  <= '0;
    end else if (state == S_WALK) begin
      if (head_res.alloc) nid_acc <= NID_W'(idx);
      if (head_res.rd_hit) rdata_acc <= head_res.rdata;
      fired_acc <= fired_acc | fire_bit;
    end
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // in the hold state the head sees slot 0 again, so take the accumulators only
  always_ff @(posedge clk) begin
    if (publish) begin
      new_id     <= (shift && head_res.alloc) ? NID_W'(idx) : nid_acc;
      read_data  <= (shift && head_res.rd_hit) ? head_res.rdata : rdata_acc;
      fired_mask <= fired_acc | (shift ? fire_bit : '0);
    end
  end

endmodule

[tb/sv/software_timer_pool_checker.sv]
`timescale 1ns / 100ps

module software_timer_pool_checker
  import stp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [3:0]        op,
  input  logic [TID_W-1:0]  timer_id,
  input  logic [VAL_W-1:0]  value,
  input  logic              one_shot,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [NID_W-1:0]  new_id,
  input  logic [VAL_W-1:0]  read_data,
  input  logic [MASK_W-1:0] fired_mask,
  output int                failures,
  output int                outstanding,
  output int                results_seen,
  output int                fire_events,
  output int                full_creates
);

  typedef struct packed {
    logic [NID_W-1:0]  nid;
    logic [VAL_W-1:0]  rdata;
    logic [MASK_W-1:0] mask;
  } timer_result_t;

  // Shadow copy of the pool
  status_t          slot_state  [NUM_TIMERS];
  logic [VAL_W-1:0] reload_val  [NUM_TIMERS];
  logic [VAL_W-1:0] count_val   [NUM_TIMERS];
  logic             mode_single [NUM_TIMERS];

  timer_result_t    pool_results_q[$];

  // Apply one command to the shadow pool and return the result it gives.
  function automatic timer_result_t apply_command(input logic [3:0]       code,
                                                  input logic [TID_W-1:0] id,
                                                  input logic [VAL_W-1:0] val,
                                                  input logic             mode);
    timer_result_t res;
    int            s;
    logic          id_ok;
    res   = '0;
    id_ok = (int'(id) < NUM_TIMERS);
    case (code)
      OP_CREATE: begin
        s = 0;
        while (s < NUM_TIMERS && slot_state[s] != ST_FREE) s++;
        if (s < NUM_TIMERS) begin
          mode_single[s] = mode;
          slot_state[s]  = ST_IDLE;
          reload_val[s]  = val;
          count_val[s]   = val;
        end
        res.nid = NID_W'(s);
      end
      OP_DESTROY: if (id_ok) begin
        count_val[id]  = '0;
        reload_val[id] = '0;
        slot_state[id] = ST_FREE;
      end
      OP_START: if (id_ok) begin
        count_val[id] = reload_val[id];
        if (slot_state[id] != ST_FREE) slot_state[id] = ST_RUNNING;
      end
      OP_STOP: if (id_ok) begin
        if (slot_state[id] != ST_FREE) slot_state[id] = ST_IDLE;
        count_val[id] = reload_val[id];
      end
      OP_RELOAD:      if (id_ok) count_val[id] = reload_val[id];
      OP_SET_RELOAD:  if (id_ok) reload_val[id] = val;
      OP_SET_COUNT:   if (id_ok) count_val[id] = val;
      OP_SET_MODE:    if (id_ok) mode_single[id] = mode;
      OP_READ_COUNT:  if (id_ok) res.rdata = count_val[id];
      OP_READ_STATUS: if (id_ok) res.rdata = VAL_W'(slot_state[id]);
      OP_TICK: begin
        for (s = 0; s < NUM_TIMERS; s++) begin
          if (slot_state[s] == ST_RUNNING) begin
            if (count_val[s] != '0) begin
              count_val[s] = count_val[s] - 1'b1;
            end else begin
              // expired: flag it, reload, and park single-shot timers
              if (s < MASK_W) res.mask[s] = 1'b1;
              count_val[s] = reload_val[s];
              if (mode_single[s]) slot_state[s] = ST_IDLE;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    timer_result_t want;
    timer_result_t got;
    int            bad;
    if (rst) begin
      for (int s = 0; s < NUM_TIMERS; s++) begin
        slot_state[s]  = ST_FREE;
        reload_val[s]  = '0;
        count_val[s]   = '0;
        mode_single[s] = 1'b0;
      end
      pool_results_q.delete();
      failures     <= 0;
      outstanding  <= 0;
      results_seen <= 0;
      fire_events  <= 0;
      full_creates <= 0;
    end else begin
      bad = 0;
      // Result beats are older than any command taken at this edge
      if (out_valid && !out_stall) begin
        got = {new_id, read_data, fired_mask};
        if (pool_results_q.size() == 0) begin
          $display("%0t: unexpected result beat new_id=%0d read_data=%h fired_mask=%h",
                   $time, got.nid, got.rdata, got.mask);
          bad++;
        end else begin
          want = pool_results_q.pop_front();
          if (got.nid != want.nid) begin
            $display("%0t: new_id expected %0d actual %0d", $time, want.nid, got.nid);
            bad++;
          end
          if (got.rdata != want.rdata) begin
            $display("%0t: read_data expected %h actual %h", $time, want.rdata, got.rdata);
            bad++;
          end
          if (got.mask != want.mask) begin
            $display("%0t: fired_mask expected %h actual %h", $time, want.mask, got.mask);
            bad++;
          end
        end
        results_seen <= results_seen + 1;
      end
      if (in_valid && !in_stall) begin
        want = apply_command(op, timer_id, value, one_shot);
        pool_results_q.push_back(want);
        fire_events <= fire_events + $countones(want.mask);
        if (op == OP_CREATE && want.nid == NID_W'(NUM_TIMERS))
          full_creates <= full_creates + 1;
      end
      failures    <= failures + bad;
      outstanding <= pool_results_q.size();
    end
  end

endmodule

[tb/sv/tb_software_timer_pool_unit.sv]
`timescale 1ns / 100ps

module tb_software_timer_pool_unit;
  import stp_pkg::*;

  // Reserved opcodes: the block must treat these as no-ops
  localparam logic [3:0] OP_RSVD_LO  = 4'd11;
  localparam logic [3:0] OP_RSVD_HI  = 4'd15;
  localparam int         ITEMS_TOTAL = 1450;
  // Final stretch run flat out, no gaps and no back-pressure
  localparam int         CALM_ITEMS  = 150;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [3:0]        op;
  logic [TID_W-1:0]  timer_id;
  logic [VAL_W-1:0]  value;
  logic              one_shot;
  logic              out_valid;
  logic              out_stall;
  logic [NID_W-1:0]  new_id;
  logic [VAL_W-1:0]  read_data;
  logic [MASK_W-1:0] fired_mask;

  int failures;
  int outstanding;
  int results_seen;
  int fire_events;
  int full_creates;
  int sent;
  int ticks;
  bit calm;

  software_timer_pool_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .timer_id   (timer_id),
    .value      (value),
    .one_shot   (one_shot),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .new_id     (new_id),
    .read_data  (read_data),
    .fired_mask (fired_mask)
  );

  software_timer_pool_checker pool_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .timer_id     (timer_id),
    .value        (value),
    .one_shot     (one_shot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .new_id       (new_id),
    .read_data    (read_data),
    .fired_mask   (fired_mask),
    .failures     (failures),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .fire_events  (fire_events),
    .full_creates (full_creates)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pick a count or reload value. Favour tiny ones so that timers
  // actually expire within a few ticks; keep the extremes and full-range
  // noise in the mix so that every bit of the field toggles.
  function automatic logic [VAL_W-1:0] pick_count();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      7:       v = '1;
      8, 9:    v = $urandom;
      default: v = VAL_W'($urandom_range(0, 4));
    endcase
    return v;
  endfunction

  // Present one command beat and hold it until the block takes it.
  // Outside the calm stretch, sometimes drop valid for a random burst
  // afterwards; otherwise leave valid high so the next beat follows
  // straight on.
  task automatic issue(input logic [3:0]       code,
                       input logic [TID_W-1:0] id,
                       input logic [VAL_W-1:0] val,
                       input logic             mode);
    int gap;
    in_valid <= 1'b1;
    op       <= code;
    timer_id <= id;
    value    <= val;
    one_shot <= mode;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (code == OP_TICK) ticks++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One create more than the pool holds: whatever the pool held before,
  // the last create of the run is bound to find it full.
  task automatic fill_pool();
    repeat (NUM_TIMERS + 1)
      issue(OP_CREATE, TID_W'($urandom), pick_count(), 1'($urandom));
  endtask

  // Receiver back-pressure: runs of free flow broken by stall bursts.
  initial begin : rx_stall
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int               r;
    logic [3:0]       code;
    logic [TID_W-1:0] id;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    op       <= OP_TICK;
    timer_id <= '0;
    value    <= '0;
    one_shot <= 1'b0;
    sent      = 0;
    ticks     = 0;
    calm      = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: fresh pool, extremes of count, expiry in both modes
    issue(OP_READ_STATUS, TID_W'(0), '0, 1'b0);
    issue(OP_READ_COUNT,  TID_W'(0), '0, 1'b0);
    issue(OP_CREATE,      TID_W'(0), '0, 1'b1);  // single shot, expires on first tick
    issue(OP_CREATE,      TID_W'(0), '1, 1'b0);  // periodic, longest count
    issue(OP_START,       TID_W'(0), '0, 1'b0);
    issue(OP_START,       TID_W'(1), '0, 1'b0);
    issue(OP_TICK,        TID_W'(0), '0, 1'b0);
    issue(OP_READ_STATUS, TID_W'(0), '0, 1'b0);
    issue(OP_READ_COUNT,  TID_W'(1), '0, 1'b0);
    issue(OP_SET_COUNT,   TID_W'(1), '0, 1'b0);
    issue(OP_TICK,        TID_W'(0), '0, 1'b0);  // periodic expiry keeps it running
    issue(OP_READ_STATUS, TID_W'(1), '0, 1'b0);
    // Writes to a slot that was never allocated still land
    issue(OP_SET_RELOAD,  TID_W'(15), 32'hA5A5_A5A5, 1'b0);
    issue(OP_SET_MODE,    TID_W'(15), '0, 1'b1);
    issue(OP_START,       TID_W'(15), '0, 1'b0);  // reloads but stays free
    issue(OP_READ_STATUS, TID_W'(15), '0, 1'b0);
    issue(OP_READ_COUNT,  TID_W'(15), '0, 1'b0);
    issue(OP_SET_COUNT,   TID_W'(15), 32'h5A5A_5A5A, 1'b0);
    issue(OP_RELOAD,      TID_W'(15), '0, 1'b0);
    issue(OP_STOP,        TID_W'(15), '0, 1'b0);
    // Destroy clears count and reload but keeps the mode
    issue(OP_STOP,        TID_W'(1), '0, 1'b0);
    issue(OP_DESTROY,     TID_W'(1), '0, 1'b0);
    issue(OP_READ_COUNT,  TID_W'(1), '0, 1'b0);
    // Reserved opcodes, with every field bit set on the last one
    issue(OP_RSVD_LO,     TID_W'(3), 32'h0000_0001, 1'b0);
    issue(OP_RSVD_HI,     '1, '1, 1'b1);
    issue(OP_TICK,        TID_W'(0), '0, 1'b0);

    // Random: mostly live timers being started and ticked, with the pool
    // filled to overflow now and then and reserved codes as noise.
    fill_pool();
    while (sent < ITEMS_TOTAL) begin
      if (sent >= ITEMS_TOTAL - CALM_ITEMS) calm = 1'b1;
      r  = $urandom_range(0, 99);
      id = TID_W'($urandom);
      if ($urandom_range(0, 199) == 0) begin
        fill_pool();
      end else if (r < 5) begin
        // arm a timer and let it run for a few ticks
        issue(OP_START, id, pick_count(), 1'($urandom));
        repeat ($urandom_range(2, 6))
          issue(OP_TICK, TID_W'($urandom), $urandom, 1'($urandom));
      end else begin
        if (r < 33)      code = OP_TICK;
        else if (r < 45) code = OP_CREATE;
        else if (r < 50) code = OP_DESTROY;
        else if (r < 60) code = OP_START;
        else if (r < 64) code = OP_STOP;
        else if (r < 68) code = OP_RELOAD;
        else if (r < 73) code = OP_SET_RELOAD;
        else if (r < 78) code = OP_SET_COUNT;
        else if (r < 82) code = OP_SET_MODE;
        else if (r < 89) code = OP_READ_COUNT;
        else if (r < 96) code = OP_READ_STATUS;
        else             code = 4'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        issue(code, id, pick_count(), 1'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted beat, then linger for strays
    do @(posedge clk); while (outstanding != 0);
    repeat (3 * NUM_TIMERS) @(posedge clk);

    $display("Sent %0d commands, %0d of them ticks; checked %0d result beats.",
             sent, ticks, results_seen);
    $display("Saw %0d timer expiries and %0d creates into a full pool.",
             fire_events, full_creates);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("Timeout with %0d results still awaited", outstanding);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
